FILE: hdl/mea_pkg.sv
// Package for the spanning-forest edge acceptor: sizes, edge-case codes,
// request and result payload structs, and controller/datapath link structs.
// Depends on nothing; every other file in hdl imports it.
`default_nettype none

package mea_pkg;

    // Vertex store geometry. NUM_VERTICES is a power of two no larger than
    // the 6-bit endpoint fields, so an endpoint modulo NUM_VERTICES is a
    // plain low-bit select.
    localparam int NUM_VERTICES = 64;
    localparam int VIDX_W       = $clog2(NUM_VERTICES);
    localparam int VFIELD_W     = 6;
    localparam int LABEL_W      = 8;
    localparam int WEIGHT_W     = 16;
    localparam int VCOUNT_W     = 7;
    localparam int CASE_W       = 3;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(64);
    localparam logic [VCOUNT_W-1:0] VCOUNT_MAX   = VCOUNT_W'(NUM_VERTICES);
    localparam logic [LABEL_W-1:0]  LABEL_FIRST  = LABEL_W'(1);

    // Edge classification codes.
    localparam logic [CASE_W-1:0] CASE_BOTH_NEW  = 3'd0;
    localparam logic [CASE_W-1:0] CASE_JOIN_FROM = 3'd1;
    localparam logic [CASE_W-1:0] CASE_JOIN_TO   = 3'd2;
    localparam logic [CASE_W-1:0] CASE_MERGE     = 3'd3;
    localparam logic [CASE_W-1:0] CASE_CYCLE     = 3'd4;

    typedef struct packed {
        logic [VFIELD_W-1:0] from_vertex;
        logic [VFIELD_W-1:0] to_vertex;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                last_edge;
    } edge_req_t;

    typedef struct packed {
        logic                accepted;
        logic [CASE_W-1:0]   edge_case;
        logic [VFIELD_W-1:0] edge_from_out;
        logic [VFIELD_W-1:0] edge_to_out;
        logic [WEIGHT_W-1:0] weight_out;
        logic [LABEL_W-1:0]  tree_label_out;
        logic                final_result;
    } edge_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic walk;
        logic wr_from;
        logic wr_to;
        logic load_out;
    } mea_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic merge_now;
        logic walk_done;
        logic out_free;
    } mea_status_t;

endpackage

`default_nettype wire

FILE: hdl/mea_ctrl.sv
// Controller state machine of the edge acceptor: sequences capture,
// classification, relabel walk, label writes and result loading.
// Depends on mea_pkg for the command and status structs.
`default_nettype none

module mea_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   edge_valid,
    output logic                  edge_ready,
    input  wire mea_pkg::mea_status_t status,
    output mea_pkg::mea_cmd_t     cmd
);
    import mea_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_WR_F = 3'd3;
    localparam logic [2:0] S_WR_T = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        edge_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                edge_ready  = 1'b1;
                cmd.capture = edge_valid;
                if (edge_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.merge_now ? S_WALK : S_WR_F;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    state_next = S_WR_F;
                end
            end
            S_WR_F:
            begin
                cmd.wr_from = 1'b1;
                state_next  = S_WR_T;
            end
            S_WR_T:
            begin
                cmd.wr_to  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/mea_datapath.sv
// Datapath of the edge acceptor: request register, in-tree flags, label
// memory, classification logic, relabel walk counter and result register.
// Depends on mea_pkg; driven by mea_ctrl through the command struct.
`default_nettype none

module mea_datapath (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire mea_pkg::edge_req_t   edge_data,
    input  wire [mea_pkg::VCOUNT_W-1:0] vertex_count,
    input  wire mea_pkg::mea_cmd_t    cmd,
    output mea_pkg::mea_status_t      status,
    output logic                      result_valid,
    input  wire                       result_ready,
    output mea_pkg::edge_result_t     result_data
);
    import mea_pkg::*;

    edge_req_t            req_reg;
    logic [NUM_VERTICES-1:0] in_tree_reg;
    logic [LABEL_W-1:0]   label_mem [NUM_VERTICES];
    logic [LABEL_W-1:0]   rd_a_reg;
    logic [LABEL_W-1:0]   rd_b_reg;
    logic [LABEL_W-1:0]   next_label_reg;
    logic [CASE_W-1:0]    case_reg;
    logic [LABEL_W-1:0]   label_reg;
    logic [LABEL_W-1:0]   la_reg;
    logic [LABEL_W-1:0]   lb_reg;
    logic [VCOUNT_W-1:0]  walk_cnt_reg;
    logic                 result_valid_reg;
    edge_result_t         result_reg;

    logic [VIDX_W-1:0]    f_idx;
    logic [VIDX_W-1:0]    t_idx;
    logic                 vf;
    logic                 vt;
    logic [LABEL_W-1:0]   lf;
    logic [LABEL_W-1:0]   lt;
    logic [CASE_W-1:0]    case_c;
    logic [LABEL_W-1:0]   label_c;
    logic [VCOUNT_W-1:0]  walk_bound;
    logic [VIDX_W-1:0]    walk_idx;
    logic                 walk_hit;
    logic                 f_writes;
    logic                 t_writes;
    logic                 mem_we;
    logic [VIDX_W-1:0]    wr_addr;
    logic [VIDX_W-1:0]    rd_addr_a;
    logic                 is_accepted;
    logic [NUM_VERTICES-1:0] join_mask;

    assign f_idx = req_reg.from_vertex[VIDX_W-1:0];
    assign t_idx = req_reg.to_vertex[VIDX_W-1:0];

    // Labels of vertices outside any tree read as zero.
    assign vf = in_tree_reg[f_idx];
    assign vt = in_tree_reg[t_idx];
    assign lf = vf ? rd_a_reg : '0;
    assign lt = vt ? rd_b_reg : '0;

    always_comb
    begin
        if (f_idx == t_idx)
        begin
            case_c  = CASE_CYCLE;
            label_c = lf;
        end
        else if (!vf && !vt)
        begin
            case_c  = CASE_BOTH_NEW;
            label_c = next_label_reg;
        end
        else if (vf && !vt)
        begin
            case_c  = CASE_JOIN_FROM;
            label_c = lf;
        end
        else if (!vf && vt)
        begin
            case_c  = CASE_JOIN_TO;
            label_c = lt;
        end
        else if (lf != lt)
        begin
            case_c  = CASE_MERGE;
            label_c = next_label_reg;
        end
        else
        begin
            case_c  = CASE_CYCLE;
            label_c = lf;
        end
    end

    assign is_accepted = (case_c != CASE_CYCLE);
    assign join_mask   = (NUM_VERTICES'(1) << f_idx) | (NUM_VERTICES'(1) << t_idx);

    // Walk covers vertices below min(vertex_count, NUM_VERTICES); entry
    // walk_cnt-1 is processed while entry walk_cnt is being read.
    assign walk_bound = (vertex_count > VCOUNT_MAX) ? VCOUNT_MAX : vertex_count;
    assign walk_idx   = VIDX_W'(walk_cnt_reg - VCOUNT_W'(1));
    assign walk_hit   = cmd.walk && (walk_cnt_reg != '0) && in_tree_reg[walk_idx]
                        && ((rd_a_reg == la_reg) || (rd_a_reg == lb_reg));

    assign f_writes = (case_reg == CASE_BOTH_NEW) || (case_reg == CASE_JOIN_TO)
                      || (case_reg == CASE_MERGE);
    assign t_writes = (case_reg == CASE_BOTH_NEW) || (case_reg == CASE_JOIN_FROM)
                      || (case_reg == CASE_MERGE);

    assign mem_we  = walk_hit || (cmd.wr_from && f_writes) || (cmd.wr_to && t_writes);
    assign wr_addr = cmd.wr_from ? f_idx : (cmd.wr_to ? t_idx : walk_idx);
    assign rd_addr_a = cmd.capture ? edge_data.from_vertex[VIDX_W-1:0]
                                   : walk_cnt_reg[VIDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            label_mem[wr_addr] <= label_reg;
        end
        rd_a_reg <= label_mem[rd_addr_a];
        rd_b_reg <= label_mem[edge_data.to_vertex[VIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= edge_data;
        end
        if (cmd.eval)
        begin
            case_reg  <= case_c;
            label_reg <= label_c;
            la_reg    <= lf;
            lb_reg    <= lt;
        end
        if (cmd.load_out)
        begin
            result_reg.accepted       <= (case_reg != CASE_CYCLE);
            result_reg.edge_case      <= case_reg;
            result_reg.edge_from_out  <= req_reg.from_vertex;
            result_reg.edge_to_out    <= req_reg.to_vertex;
            result_reg.weight_out     <= req_reg.edge_weight;
            result_reg.tree_label_out <= label_reg;
            result_reg.final_result   <= req_reg.last_edge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tree_reg      <= '0;
            next_label_reg   <= LABEL_FIRST;
            walk_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                walk_cnt_reg <= '0;
                if (is_accepted)
                begin
                    in_tree_reg <= in_tree_reg | join_mask;
                end
                if ((case_c == CASE_BOTH_NEW) || (case_c == CASE_MERGE))
                begin
                    next_label_reg <= next_label_reg + LABEL_W'(1);
                end
            end
            else if (cmd.walk && (walk_cnt_reg != walk_bound))
            begin
                walk_cnt_reg <= walk_cnt_reg + VCOUNT_W'(1);
            end

            if (cmd.load_out)
            begin
                result_valid_reg <= 1'b1;
                if (req_reg.last_edge)
                begin
                    in_tree_reg    <= '0;
                    next_label_reg <= LABEL_FIRST;
                end
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign status.merge_now = (case_c == CASE_MERGE);
    assign status.walk_done = (walk_cnt_reg == walk_bound);
    assign status.out_free  = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

`default_nettype wire

FILE: hdl/mst_edge_acceptor_top.sv
// Top level of the spanning-forest edge acceptor: configuration register
// and the controller/datapath pair. Depends on mea_pkg, mea_ctrl and
// mea_datapath.
// A non-merging edge passes from acceptance through classification and the
// label writes to a loaded result; a merging edge also runs the relabel walk
// over the vertices below min(vertex_count, 64), reading one label memory entry
// per cycle. A new request is accepted only once the last result is loaded.
// Reset (rst_n, asynchronous): all vertices leave their trees, the next
// label returns to 1 and vertex_count returns to 64.
`default_nettype none

module mst_edge_acceptor_top (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         edge_valid,
    output logic                        edge_ready,
    input  wire mea_pkg::edge_req_t     edge_data,
    output logic                        result_valid,
    input  wire                         result_ready,
    output mea_pkg::edge_result_t       result_data,
    input  wire                         cfg_wr_en,
    input  wire [mea_pkg::VCOUNT_W-1:0] cfg_wr_data
);
    import mea_pkg::*;

    // The vertex count bounds the relabel walk; it survives the store
    // clearing that follows the last edge of a graph.
    logic [VCOUNT_W-1:0] vertex_count_reg;
    mea_cmd_t            cmd;
    mea_status_t         status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    // The controller only sequences; every label decision is in the datapath.
    mea_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (edge_valid),
        .edge_ready (edge_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath owns the vertex store and the result register, so a
    // finished result can wait for the consumer while the next request
    // is taken in.
    mea_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_data    (edge_data),
        .vertex_count (vertex_count_reg),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

FILE: hdl/mea_checker.sv
// Port-level checker for the edge acceptor, bound to the top level.
// Depends on mea_pkg and mst_edge_acceptor_top.
`default_nettype none

module mea_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         edge_valid,
    input wire                         edge_ready,
    input wire                         result_valid,
    input wire                         result_ready,
    input wire mea_pkg::edge_result_t  result_data
);
    import mea_pkg::*;

    // One request is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && edge_ready |=> !edge_ready)
        else $error("edge_ready stayed high after a request was accepted");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    a_accept_matches_case: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.accepted == (result_data.edge_case != CASE_CYCLE)))
        else $error("accepted flag disagrees with edge case");

    a_self_loop_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.edge_from_out == result_data.edge_to_out)
        |-> !result_data.accepted)
        else $error("self-loop was accepted");

endmodule

bind mst_edge_acceptor_top mea_checker u_mea_checker (.*);

`default_nettype wire
